[rtl/tfrg_pkg.sv]
// Shared types and constants of the transfer function ramp generator.
// Used by the divider and the top level; depends on nothing else.
`default_nettype none

package tfrg_pkg;

    localparam int TABLE_SIZE_DEF = 512;
    localparam int MAX_POINTS_DEF = 16;

    // shared divider: signed dividend, unsigned divisor
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 18;

    // multiply-accumulate operand and accumulator widths
    localparam int MAC_W = 18;
    localparam int ACC_W = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EMIT   = 2'd2;

    localparam logic REG_MIN = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_VDIV,
        S_VWAIT,
        S_WALK,
        S_SPAN,
        S_C0,
        S_C1,
        S_C2,
        S_CDIV,
        S_CWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic floor_mode;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/tfrg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module tfrg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/tfrg_div.sv]
// Iterative restoring divider, one quotient bit per cycle, with truncating
// or flooring signed result. Depends on tfrg_pkg.
`default_nettype none

module tfrg_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tfrg_pkg::t_div_req                i_req,
    input  wire logic signed [tfrg_pkg::DIV_NW-1:0] i_dividend,
    input  wire logic [tfrg_pkg::DIV_DW-1:0]       i_divisor,
    output tfrg_pkg::t_div_rsp                     o_rsp
);

    import tfrg_pkg::*;

    localparam int SW = $clog2(DIV_NW);

    logic                     r_busy;
    logic                     r_fix;
    logic                     r_done;
    logic [SW-1:0]            r_step;
    logic [DIV_NW-1:0]        r_mag;
    logic [DIV_DW-1:0]        r_rem;
    logic [DIV_DW-1:0]        r_div;
    logic                     r_neg;
    logic                     r_floor;
    logic signed [DIV_NW-1:0] r_quot;

    logic [DIV_DW:0] trial;
    logic            ge;

    assign trial = {r_rem, r_mag[DIV_NW-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // pulse done for one cycle after the sign fix
            r_done <= r_fix && !r_busy && !i_req.start;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_rem   <= '0;
                r_div   <= i_divisor;
                r_neg   <= i_dividend[DIV_NW-1];
                r_floor <= i_req.floor_mode;
                r_mag   <= i_dividend[DIV_NW-1] ? DIV_NW'(-i_dividend) : DIV_NW'(i_dividend);
            end else if (r_busy) begin
                // shift in one quotient bit
                r_rem  <= ge ? DIV_DW'(trial - {1'b0, r_div}) : DIV_DW'(trial);
                r_mag  <= {r_mag[DIV_NW-2:0], ge};
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                // restore sign; floor takes one more step down on a remainder
                if (!r_neg) begin
                    r_quot <= $signed(r_mag);
                end else if (r_floor && (r_rem != '0)) begin
                    r_quot <= $signed(~r_mag);
                end else begin
                    r_quot <= $signed(-r_mag);
                end
                r_fix  <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

[rtl/transfer_function_ramp_generator.sv]
// Piecewise-linear RGBA ramp generator: control point list, segment walk,
// shared multiply-accumulate and shared divider. Uses tfrg_pkg, tfrg_ram, tfrg_div.
//
// Input stream: tuser carries the command, tdata the point value and color.
//   Clear and append words are taken without leaving idle; ready stays high.
//   An emit word drops ready until its entry is built and loaded into the
//   output register. The 32-step divider runs once for the sample value and
//   once per color channel (a channel of a zero-length segment takes no
//   division). No new command is taken while an entry is being built.
// Output stream: one word per emit; tdata holds index and RGBA, tlast marks
//   the final table entry. The result sits in an output register, so the
//   next command is taken while it waits; a stalled receiver only holds the
//   block once a second entry is finished and the register is still full.
// APB port: min_value at 0x0, max_value at 0x4; write only while idle.
// Reset (synchronous, active low): empty point list, entry counter at zero,
//   min_value 0, max_value 4095, output empty. The point store is not cleared.
`default_nettype none

module transfer_function_ramp_generator #(
    parameter int TABLE_SIZE = tfrg_pkg::TABLE_SIZE_DEF,
    parameter int MAX_POINTS = tfrg_pkg::MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: point_value[15:0], point_red[23:16], point_green[31:24],
    //        point_blue[39:32], point_alpha[47:40]
    input  wire logic [47:0] i_s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: entry_index[8:0], out_red[16:9], out_green[24:17],
    //        out_blue[32:25], out_alpha[40:33], zero[47:41]
    output logic [47:0]      o_m_axis_tdata,
    // tlast: last_entry
    output logic             o_m_axis_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import tfrg_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SIZE);
    localparam int PT_W  = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int RAM_W = 48;

    t_state r_state, n_state;

    logic signed [15:0]      r_min, r_max;
    logic [PT_W-1:0]         r_total, r_np;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [16:0]      r_low, r_high, r_v;
    logic [31:0]             r_low_color, r_high_color;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [MAC_W-1:0] r_span, r_t;
    logic [1:0]              r_ch;
    logic [3:0][7:0]         r_color;
    logic                    r_out_valid;
    logic [8:0]              r_out_index;
    logic [31:0]             r_out_color;
    logic                    r_out_last;

    logic        s_ready, in_accept, out_load, cfg_write, is_last, restart;
    logic [1:0]  in_cmd;
    logic signed [15:0] in_value;
    logic [31:0] in_color;

    logic [RAM_W-1:0]   ram_rdata;
    logic signed [15:0] ram_value;
    logic               ram_we;

    logic signed [MAC_W-1:0]   mac_a, mac_b;
    logic signed [2*MAC_W-1:0] mac_prod;
    logic signed [ACC_W-1:0]   mac_lo;

    logic signed [MAC_W-1:0] span_raw, t_raw;
    logic [7:0]              lc, hc, clamped;

    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic [DIV_DW-1:0]    div_divisor;

    assign in_cmd    = i_s_axis_tuser;
    assign in_value  = i_s_axis_tdata[15:0];
    assign in_color  = i_s_axis_tdata[47:16];
    assign in_accept = i_s_axis_tvalid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign is_last   = (r_cnt == CNT_W'(TABLE_SIZE - 1));
    assign restart   = (in_cmd == CMD_CLEAR) || (r_cnt == '0);

    assign ram_we    = in_accept && (in_cmd == CMD_APPEND) && (r_total < PT_W'(MAX_POINTS));
    assign ram_value = ram_rdata[15:0];

    assign lc = r_low_color[{r_ch, 3'b000} +: 8];
    assign hc = r_high_color[{r_ch, 3'b000} +: 8];

    assign span_raw = MAC_W'(r_high) - MAC_W'(r_low);
    assign t_raw    = MAC_W'(r_v) - MAC_W'(r_low);

    assign mac_prod = mac_a * mac_b;
    assign mac_lo   = $signed(mac_prod[ACC_W-1:0]);

    always_comb begin
        if (div_rsp.quot < 0) begin
            clamped = 8'd0;
        end else if (div_rsp.quot > 32'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = div_rsp.quot[7:0];
        end
    end

    tfrg_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata ({in_color, in_value}),
        .i_raddr (r_np[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    tfrg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_acc),
        .i_divisor  (div_divisor),
        .o_rsp      (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept && (in_cmd == CMD_EMIT)) n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_VDIV;
            S_VDIV:  n_state = S_VWAIT;
            S_VWAIT: if (div_rsp.done) n_state = S_WALK;
            S_WALK:  n_state = S_SPAN;
            S_SPAN:  n_state = S_C0;
            S_C0: begin
                if (r_span != '0) begin
                    n_state = S_C1;
                end else if (r_ch == 2'd3) begin
                    n_state = S_OUT;
                end
            end
            S_C1:    n_state = S_C2;
            S_C2:    n_state = S_CDIV;
            S_CDIV:  n_state = S_CWAIT;
            S_CWAIT: if (div_rsp.done) n_state = (r_ch == 2'd3) ? S_OUT : S_C0;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready            = 1'b0;
        out_load           = 1'b0;
        div_req.start      = 1'b0;
        div_req.floor_mode = 1'b0;
        div_divisor        = DIV_DW'(TABLE_SIZE);
        mac_a              = '0;
        mac_b              = '0;
        unique case (r_state)
            S_IDLE: s_ready = 1'b1;
            S_M0: begin
                mac_a = MAC_W'(r_min);
                mac_b = MAC_W'(TABLE_SIZE);
            end
            S_M1: begin
                mac_a = MAC_W'(r_cnt);
                mac_b = MAC_W'(r_max) - MAC_W'(r_min);
            end
            S_VDIV: div_req.start = 1'b1;
            S_C0: begin
                mac_a = MAC_W'(lc);
                mac_b = r_span;
            end
            S_C1: begin
                mac_a = MAC_W'(hc) - MAC_W'(lc);
                mac_b = r_t;
            end
            S_CDIV: begin
                div_req.start      = 1'b1;
                div_req.floor_mode = 1'b1;
                div_divisor        = {r_span[DIV_DW-2:0], 1'b0};
            end
            S_OUT: out_load = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min        <= 16'sd0;
            r_max        <= 16'sd4095;
            r_total      <= '0;
            r_cnt        <= '0;
            r_np         <= '0;
            r_low        <= 17'sd0;
            r_high       <= 17'sd1;
            r_low_color  <= '0;
            r_high_color <= '0;
            r_ch         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_write) begin
                unique case (paddr[2])
                    REG_MIN: r_min <= pwdata[15:0];
                    REG_MAX: r_max <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_index <= 9'(r_cnt);
                r_out_color <= r_color;
                r_out_last  <= is_last;
                r_cnt       <= is_last ? '0 : r_cnt + 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (in_cmd == CMD_CLEAR) begin
                            r_total <= '0;
                            r_cnt   <= '0;
                        end else if (ram_we) begin
                            r_total <= r_total + 1'b1;
                        end
                        // rewind the walk on clear and on the first entry
                        if ((in_cmd == CMD_CLEAR || in_cmd == CMD_EMIT) && restart) begin
                            r_np         <= '0;
                            r_low        <= 17'(r_min);
                            r_high       <= 17'(r_min) + 17'sd1;
                            r_low_color  <= '0;
                            r_high_color <= '0;
                        end
                    end
                end
                S_M0: r_acc <= mac_lo;
                S_M1: r_acc <= r_acc + mac_lo;
                S_VWAIT: if (div_rsp.done) r_v <= 17'(div_rsp.quot);
                S_WALK: begin
                    // advance one point when the sample passes the high end
                    if (r_high < r_v) begin
                        r_low       <= r_high;
                        r_low_color <= r_high_color;
                        if (r_np < r_total) begin
                            r_high       <= 17'(ram_value);
                            r_high_color <= ram_rdata[47:16];
                            r_np         <= r_np + 1'b1;
                        end else begin
                            r_high <= 17'(r_max);
                        end
                    end
                end
                S_SPAN: begin
                    r_span <= (span_raw < 0) ? -span_raw : span_raw;
                    r_t    <= (span_raw < 0) ? -t_raw : t_raw;
                    r_ch   <= '0;
                end
                S_C0: begin
                    if (r_span == '0) begin
                        r_color[r_ch] <= lc;
                        r_ch          <= r_ch + 1'b1;
                    end else begin
                        r_acc <= mac_lo;
                    end
                end
                S_C1: r_acc <= r_acc + mac_lo;
                // numerator for rounding: 2*(lc*span + dc*t) + span
                S_C2: r_acc <= (r_acc <<< 1) + ACC_W'(r_span);
                S_CWAIT: begin
                    if (div_rsp.done) begin
                        r_color[r_ch] <= clamped;
                        r_ch          <= r_ch + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN: prdata = {{16{r_min[15]}}, r_min};
            REG_MAX: prdata = {{16{r_max[15]}}, r_max};
            default: prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_color, r_out_index};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= PT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_np <= r_total)
        else $error("segment walk beyond stored points");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_VWAIT || r_state == S_CWAIT))
        else $error("divider result outside a wait state");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && is_last) |=> (r_cnt == '0))
        else $error("entry counter did not wrap after last entry");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !out_load)
        else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire

[verif/tb_transfer_function_ramp_generator.sv]
// Self-checking bench for transfer_function_ramp_generator: streams point and emit
// commands, predicts every color table entry locally and checks the output words.
// Depends on tfrg_pkg and the block's RTL only.

module tb_transfer_function_ramp_generator;
    import tfrg_pkg::*;

    localparam int ENTRIES = TABLE_SIZE_DEF;
    localparam int POINTS = MAX_POINTS_DEF;
    localparam logic [1:0] CMD_SKIP = 2'd3;
    localparam int ITEMS_TARGET = 1650;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_OFF = 1500;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [8:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_ramp_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // tdata: point_value[15:0], red[23:16], green[31:24], blue[39:32], alpha[47:40]
    logic [47:0] i_s_axis_tdata = '0;
    // tuser: command[1:0]
    logic [1:0]  i_s_axis_tuser = CMD_CLEAR;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // tdata: entry_index[8:0], red[16:9], green[24:17], blue[32:25], alpha[40:33]
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the ramp state
    int          cfg_min = 0;
    int          cfg_max = 4095;
    int          ctrl_value [POINTS];
    logic [31:0] ctrl_rgba [POINTS];
    int          ctrl_count = 0;
    int          ramp_pos = 0;
    int          walk_next = 0;
    longint      seg_lo = 0;
    longint      seg_hi = 1;
    logic [31:0] seg_lo_rgba = '0;
    logic [31:0] seg_hi_rgba = '0;
    t_ramp_entry pending_entries [$];

    int words_sent = 0;
    int entries_checked = 0;
    int reg_writes = 0;
    int errors = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit calm = 1'b0;

    transfer_function_ramp_generator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tlast(o_m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void restart_walk();
        walk_next = 0;
        seg_lo = cfg_min;
        seg_hi = cfg_min + 1;
        seg_lo_rgba = '0;
        seg_hi_rgba = '0;
    endfunction

    // round half up, then clamp to a byte
    function automatic logic [7:0] blend_channel(longint lc, longint hc, longint t,
                                                 longint span);
        longint num, den, q;
        if (span == 0) return lc[7:0];
        if (span < 0) begin
            span = -span;
            t = -t;
        end
        num = 2 * (lc * span + (hc - lc) * t) + span;
        den = 2 * span;
        q = num / den;
        if (num % den != 0 && num < 0) q--;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic void predict_word(logic [1:0] cmd, int value, logic [31:0] rgba);
        longint v, t, span;
        t_ramp_entry e;
        case (cmd)
            CMD_CLEAR: begin
                ctrl_count = 0;
                ramp_pos = 0;
                restart_walk();
            end
            CMD_APPEND: begin
                if (ctrl_count < POINTS) begin
                    ctrl_value[ctrl_count] = value;
                    ctrl_rgba[ctrl_count] = rgba;
                    ctrl_count++;
                end
            end
            CMD_EMIT: begin
                if (ramp_pos == 0) restart_walk();
                v = (longint'(cfg_min) * ENTRIES
                     + longint'(ramp_pos) * (longint'(cfg_max) - cfg_min)) / ENTRIES;
                // advance the walk by one point at most per entry
                if (seg_hi < v) begin
                    seg_lo = seg_hi;
                    seg_lo_rgba = seg_hi_rgba;
                    if (walk_next < ctrl_count) begin
                        seg_hi = ctrl_value[walk_next];
                        seg_hi_rgba = ctrl_rgba[walk_next];
                        walk_next++;
                    end else begin
                        seg_hi = cfg_max;
                    end
                end
                span = seg_hi - seg_lo;
                t = v - seg_lo;
                e.index = 9'(ramp_pos);
                e.red = blend_channel(seg_lo_rgba[7:0], seg_hi_rgba[7:0], t, span);
                e.green = blend_channel(seg_lo_rgba[15:8], seg_hi_rgba[15:8], t, span);
                e.blue = blend_channel(seg_lo_rgba[23:16], seg_hi_rgba[23:16], t, span);
                e.alpha = blend_channel(seg_lo_rgba[31:24], seg_hi_rgba[31:24], t, span);
                e.last = (ramp_pos == ENTRIES - 1);
                ramp_pos = (ramp_pos + 1 >= ENTRIES) ? 0 : ramp_pos + 1;
                pending_entries = {pending_entries, e};
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_ramp_entry want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_entries.size() == 0) begin
                $error("output word with no entry pending: tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_entries.pop_front();
                check_field("entry_index", want.index, o_m_axis_tdata[8:0]);
                check_field("out_red", want.red, o_m_axis_tdata[16:9]);
                check_field("out_green", want.green, o_m_axis_tdata[24:17]);
                check_field("out_blue", want.blue, o_m_axis_tdata[32:25]);
                check_field("out_alpha", want.alpha, o_m_axis_tdata[40:33]);
                check_field("tdata padding", 0, o_m_axis_tdata[47:41]);
                check_field("last_entry", want.last, o_m_axis_tlast);
                entries_checked++;
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles--;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    task automatic send_word(logic [1:0] cmd, int value, logic [31:0] rgba);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= cmd;
        i_s_axis_tdata <= {rgba, 16'(value)};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_word(cmd, value, rgba);
        words_sent++;
    endtask

    task automatic send_emits(int count);
        repeat (count) send_word(CMD_EMIT, 0, '0);
    endtask

    // drop valid, wait out every pending entry, then let the block go quiet
    task automatic settle_block();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_MIN) cfg_min = value;
        else cfg_max = value;
        reg_writes++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic int pick_bound();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // point k of n, spread over the part of the range that reach entries will sample
    function automatic int spread_value(int k, int n, int reach);
        longint pos;
        if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 65535)) - 32768;
        pos = cfg_min + (longint'(cfg_max) - cfg_min) * (k + 1) * reach / ((n + 1) * ENTRIES)
              + int'($urandom_range(0, 8)) - 4;
        if (pos < -32768) pos = -32768;
        if (pos > 32767) pos = 32767;
        return int'(pos);
    endfunction

    task automatic test_reset_ramp();
        // empty list under the reset range, then a point added mid-table
        send_emits(3);
        send_word(CMD_APPEND, 1000, 32'hFFFF_FFFF);
        send_emits(3);
    endtask

    task automatic test_directed_points();
        settle_block();
        write_reg(REG_MIN, -32768);
        write_reg(REG_MAX, 32767);
        send_word(CMD_CLEAR, 0, '0);
        send_word(CMD_APPEND, -32700, 32'hFFFF_FFFF);
        // same value twice gives a zero-length segment
        send_word(CMD_APPEND, -32700, 32'h00FF_00FF);
        send_word(CMD_APPEND, -32500, 32'h8040_2010);
        // out of order, then the top of the range
        send_word(CMD_APPEND, -32768, 32'h00FF_FF00);
        send_word(CMD_SKIP, 32767, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 32767, 32'h0000_0000);
        send_emits(10);
    endtask

    task automatic test_full_table();
        settle_block();
        write_reg(REG_MIN, -32768);
        write_reg(REG_MAX, 32767);
        calm = 1'b1;
        send_word(CMD_CLEAR, 0, '0);
        // one past capacity: the last append is dropped
        for (int k = 0; k <= POINTS; k++)
            send_word(CMD_APPEND, spread_value(k, POINTS, ENTRIES), $urandom());
        send_emits(ENTRIES + 3);
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        settle_block();
        calm = 1'b1;
        send_word(CMD_CLEAR, 0, '0);
        for (int k = 0; k < 3; k++)
            send_word(CMD_APPEND, spread_value(k, 3, 12), $urandom());
        hold_cycles = HOLD_OFF;
        send_emits(10);
        settle_block();
        calm = 1'b0;
    endtask

    task automatic test_random_tables();
        int lo, hi, swap, n_pts, n_emit;
        while (words_sent < ITEMS_TARGET) begin
            settle_block();
            lo = pick_bound();
            hi = pick_bound();
            if (lo > hi && $urandom_range(0, 9) < 7) begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            if ($urandom_range(0, 6) == 0) hi = (lo > 32727) ? 32767 : lo + $urandom_range(0, 40);
            write_reg(REG_MIN, lo);
            write_reg(REG_MAX, hi);
            // now and then keep the current table and list going
            if ($urandom_range(0, 9) != 0) send_word(CMD_CLEAR, 0, '0);
            n_emit = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(4, 30);
            n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19)
                                                 : $urandom_range(0, 6);
            for (int k = 0; k < n_pts; k++)
                send_word(CMD_APPEND, spread_value(k, n_pts, ramp_pos + n_emit), $urandom());
            for (int k = 0; k < n_emit; k++) begin
                if ($urandom_range(0, 99) < 8)
                    send_word(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)) - 32768,
                              $urandom());
                else
                    send_word(CMD_EMIT, 0, '0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_ramp();
        test_directed_points();
        test_full_table();
        test_backpressure();
        test_random_tables();
        settle_block();
        $display("sent %0d command words, checked %0d table entries, %0d register writes",
                 words_sent, entries_checked, reg_writes);
        $display("ran a full table with wrap, an overfull point list and a long output hold");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tfrg_pkg.sv
rtl/tfrg_ram.sv
rtl/tfrg_div.sv
rtl/transfer_function_ramp_generator.sv
verif/tb_transfer_function_ramp_generator.sv
